FILE: hw/rtl/rwf_pkg.sv
// Shared types, constants and a helper function for the RGB 3x3 window filter.
`default_nettype none

package rwf_pkg;

   localparam int CH_W         = 8;
   localparam int NUM_CH       = 3;
   localparam int PIX_W        = CH_W * NUM_CH;
   localparam int WIN_SIZE     = 9;
   localparam int WIN_CENTER   = 4;
   localparam int CENTER_GAIN  = 5;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int CMP_W        = 14;
   localparam int ROW_W        = 13;
   localparam int FW_W         = 11;
   localparam int FH_W         = 13;
   localparam int ACC_W        = 13;
   localparam int CNT_W        = 4;
   localparam int RECIP_W      = 17;
   localparam int RECIP_SHIFT  = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic MODE_BLUR    = 1'b0;
   localparam logic MODE_SHARPEN = 1'b1;

   localparam logic [FW_W-1:0] FW_RESET = 11'd640;
   localparam logic [FH_W-1:0] FH_RESET = 13'd480;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_OUT
   } rwf_state_type;

   // 2^16 / count rounded up; exact for sums up to 9 * 255.
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
      logic [RECIP_W-1:0] r;
      case (count)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd6:    r = 17'd10923;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rwf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rwf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_window_filter_3x3_top.sv
// Top level of the RGB 3x3 box blur / sharpen window filter.
//
//  channel | direction | tdata (low bit up)                 | tuser
//  req     | in        | red[7:0] green[15:8] blue[23:16]   | drain
//  rsp     | out       | red_out green_out blue_out         | frame_end
//  csr     | in        | csr_we, csr_index, csr_wdata[12:0] | -
//
// A request that yields no result passes through accept and line store read;
// one that yields a result also passes through window sum and divide/clamp.
// The result stage stalls while rsp holds an untaken result; req waits meanwhile.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
`default_nettype none

module rgb_window_filter_3x3_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [rwf_pkg::PIX_W-1:0]       req_tdata,   // red, green, blue
   input  wire logic                            req_tuser,   // drain
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [rwf_pkg::PIX_W-1:0]       rsp_tdata,   // red_out, green_out, blue_out
   output logic                                 rsp_tuser,   // frame_end
   input  wire logic                            csr_we,
   input  wire logic [rwf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rwf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rwf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   rwf_state_type   state_ff, state_in;
   logic            mode_ff, mode_in;
   logic [FW_W-1:0] fwidth_ff, fwidth_in;
   logic [FH_W-1:0] fheight_ff, fheight_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   pixel_type       pix_ff, pix_in;
   pixel_type       win_ff [WIN_SIZE];
   pixel_type       win_in [WIN_SIZE];
   logic signed [ACC_W-1:0] val_ff [NUM_CH];
   logic signed [ACC_W-1:0] val_in [NUM_CH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   pixel_type       rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0] w_eff;
   logic [CMP_W-1:0] h_eff;
   logic            row_top, row_bot, col_left, col_right;
   logic [WIN_SIZE-1:0] vmask;
   logic            req_accept;
   logic            mem_we;
   pixel_type       rd_above, rd_two;
   logic            rsp_load;

   assign w_eff = (fwidth_ff == '0) ? CMP_W'(1) :
                  (CMP_W'(fwidth_ff) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) :
                  CMP_W'(fwidth_ff);
   assign h_eff = (fheight_ff == '0) ? CMP_W'(1) :
                  (CMP_W'(fheight_ff) > CMP_W'(HEIGHT_LIMIT)) ? CMP_W'(HEIGHT_LIMIT) :
                  CMP_W'(fheight_ff);

   assign row_top   = (out_row_ff != '0);
   assign row_bot   = (CMP_W'(out_row_ff) + CMP_W'(1)) < h_eff;
   assign col_left  = (out_col_ff != '0);
   assign col_right = (CMP_W'(out_col_ff) + CMP_W'(1)) < w_eff;

   always_comb begin
      logic [2:0] rok;
      logic [2:0] cok;
      rok = {row_bot, 1'b1, row_top};
      cok = {col_right, 1'b1, col_left};
      for (int dy = 0; dy < 3; dy++) begin
         for (int dx = 0; dx < 3; dx++) begin
            vmask[dy*3+dx] = rok[dy] & cok[dx];
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign mem_we     = (state_ff == ST_READ);
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   rwf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_above_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (in_col_ff),
      .wr_data (pix_ff),
      .rd_addr (in_col_ff),
      .rd_data (rd_above)
   );

   rwf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_two_above_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (in_col_ff),
      .wr_data (rd_above),
      .rd_addr (in_col_ff),
      .rd_data (rd_two)
   );

   always_comb begin
      logic                     emit;
      logic [ACC_W-1:0]         sum;
      logic signed [ACC_W-1:0]  acc;
      logic [RECIP_W-1:0]       rcp;
      logic [ACC_W+RECIP_W-1:0] prod;
      logic [CH_W-1:0]          res;
      logic                     last;

      state_in     = state_ff;
      mode_in      = mode_ff;
      fwidth_in    = fwidth_ff;
      fheight_in   = fheight_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      pix_in       = pix_ff;
      win_in       = win_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      emit         = 1'b0;
      last         = 1'b0;
      sum          = '0;
      acc          = '0;
      rcp          = '0;
      prod         = '0;
      res          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && !(req_tuser && in_col_ff == '0 && in_row_ff == '0)) begin
               pix_in   = req_tuser ? '0 : req_tdata;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            for (int dy = 0; dy < 3; dy++) begin
               win_in[dy*3+0] = win_ff[dy*3+1];
               win_in[dy*3+1] = win_ff[dy*3+2];
            end
            win_in[2] = rd_two;
            win_in[5] = rd_above;
            win_in[8] = pix_ff;
            emit = (in_row_ff >= ROW_W'(2)) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
            if ((CMP_W'(in_col_ff) + CMP_W'(1)) >= w_eff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
            state_in = emit ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            for (int c = 0; c < NUM_CH; c++) begin
               sum = '0;
               acc = ACC_W'(CENTER_GAIN) * $signed({5'b0, win_ff[WIN_CENTER][c*CH_W +: CH_W]});
               for (int i = 0; i < WIN_SIZE; i++) begin
                  if (vmask[i]) begin
                     sum = sum + ACC_W'(win_ff[i][c*CH_W +: CH_W]);
                     if (i % 2 == 1) begin
                        acc = acc - $signed({5'b0, win_ff[i][c*CH_W +: CH_W]});
                     end
                  end
               end
               val_in[c] = (mode_ff == MODE_SHARPEN) ? acc : $signed(sum);
            end
            count_in = CNT_W'($countones(vmask));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               rcp = recip(count_ff);
               for (int c = 0; c < NUM_CH; c++) begin
                  prod = ACC_W'(val_ff[c]) * rcp;
                  if (mode_ff == MODE_SHARPEN) begin
                     if (val_ff[c] < 0) begin
                        res = '0;
                     end else if (val_ff[c] > 255) begin
                        res = '1;
                     end else begin
                        res = val_ff[c][CH_W-1:0];
                     end
                  end else begin
                     res = prod[RECIP_SHIFT +: CH_W];
                  end
                  rsp_data_in[c*CH_W +: CH_W] = res;
               end
               last         = !row_bot && !col_right;
               rsp_last_in  = last;
               rsp_valid_in = 1'b1;
               if (col_right) begin
                  out_col_in = out_col_ff + 1'b1;
               end else begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end
               if (last) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
                  for (int i = 0; i < WIN_SIZE; i++) begin
                     win_in[i] = '0;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[0];
            end
            CSR_WIDTH, CSR_HEIGHT: begin
               if (csr_index == CSR_WIDTH) begin
                  fwidth_in = csr_wdata[FW_W-1:0];
               end else begin
                  fheight_in = csr_wdata[FH_W-1:0];
               end
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               for (int i = 0; i < WIN_SIZE; i++) begin
                  win_in[i] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_BLUR;
         fwidth_ff    <= FW_RESET;
         fheight_ff   <= FH_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WIN_SIZE; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         fwidth_ff    <= fwidth_in;
         fheight_ff   <= fheight_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      pix_ff      <= pix_in;
      val_ff      <= val_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_last_ff;

   // frame end restarts both position counters
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (in_col_ff == '0 && in_row_ff == '0 &&
                                     out_col_ff == '0 && out_row_ff == '0))
      else $error("counters not cleared after frame end");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(in_col_ff) < w_eff) && (CMP_W'(out_col_ff) < w_eff))
      else $error("column counter beyond frame width");

   // line store data is consumed in the cycle after the request that issued the read was accepted
   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(state_ff) == ST_IDLE && $past(req_accept)))
      else $error("line store data used without a preceding request");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (count_ff != '0))
      else $error("blur divisor is zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule

`default_nettype wire
